### hw/rtl/crmv_pkg.sv
// ----------------------------------------------------------------------------
// crmv_pkg: shared types and constants
// Field widths, fixed-point format, operation codes and the control struct
// passed from the input stage to the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package crmv_pkg;

	// Field widths.
	localparam int IDX_W   = 12;
	localparam int VALUE_W = 32;
	localparam int FRAC_W  = VALUE_W - 8;
	localparam int ACC_W   = 64;
	localparam int COEF_W  = VALUE_W + 1;
	localparam int FUNC_W  = 2;

	// Vector store depth, addressed by the full column index.
	localparam int X_DEPTH = 1 << IDX_W;

	// Item operation codes.
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ENTRY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_EMPTY = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_INDEX = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_DIAG  = 1'b1;

	// Accumulator bounds.
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Output clip bounds.
	localparam logic [VALUE_W-1:0] Y_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] Y_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// Coefficient that turns x into -x placed in the product format.
	localparam logic signed [COEF_W-1:0] COEF_NEG_ONE =
		-(COEF_W'(1) <<< FRAC_W);

	// Control that travels along the datapath with each item.
	typedef struct packed {
		logic             vld;
		logic             empty;
		logic             last;
		logic [IDX_W-1:0] row;
	} crmv_ctrl_t;

endpackage

### hw/rtl/csr_matvec_ref_row_shift.sv
// ----------------------------------------------------------------------------
// csr_matvec_ref_row_shift: streaming CSR matrix-vector product
// Loads a dense vector, then accumulates one row of sparse entries at a time
// with a reference-row shift and emits the negated row sum in Q8.24.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low; busy is always low, so one item
//   is taken every cycle. func selects a vector load, a matrix entry or an
//   empty row. Configuration (ref_index, ref_diag) must be written on the cfg
//   channel, which is always ready, only while no item is in flight; the block
//   does not enforce this. A result appears on out_row, y_value and saturated
//   for exactly one cycle with done high, once the last entry of a row or an
//   empty-row item passes the input, product, accumulator and result stages.
//   Results leave in item order.
//   Throughput is one item per cycle, set by the single read port of the
//   vector store and the one multiplier feeding the accumulator.
//   The receiver cannot stall; every result must be taken when shown.
//   Reset clears the pipeline controls, the accumulator and both configuration
//   registers. The vector store is not cleared; load it before use.
// ----------------------------------------------------------------------------
module csr_matvec_ref_row_shift import crmv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [FUNC_W-1:0]    func,
	input  logic [IDX_W-1:0]     row,
	input  logic [IDX_W-1:0]     col,
	input  logic [VALUE_W-1:0]   value,
	input  logic                 last_in_row,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VALUE_W-1:0]   cfg_data,
	output logic                 done,
	output logic [IDX_W-1:0]     out_row,
	output logic [VALUE_W-1:0]   y_value,
	output logic                 saturated
);

	logic                      accept;
	logic                      load_we;
	logic [IDX_W-1:0]          ref_index_q;
	logic signed [VALUE_W-1:0] ref_diag_q;
	logic [VALUE_W-1:0]        x_mem [X_DEPTH];
	logic signed [VALUE_W-1:0] x_rd_s1;
	logic signed [COEF_W-1:0]  val_ext;
	logic signed [COEF_W-1:0]  coef_next;
	logic signed [COEF_W-1:0]  coef_s1;
	crmv_ctrl_t                ctrl_next;
	crmv_ctrl_t                ctrl_s1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign load_we   = accept && (func == FUNC_LOAD);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_index_q <= '0;
			ref_diag_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REF_INDEX: ref_index_q <= cfg_data[IDX_W-1:0];
				CFG_REF_DIAG:  ref_diag_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Vector store: written by load items, read for every item.
	always_ff @(posedge clk) begin
		if (load_we) begin
			x_mem[col] <= value;
		end
		x_rd_s1 <= x_mem[col];
	end

	// Pick the coefficient that multiplies x[col] for this entry.
	always_comb begin
		val_ext = {value[VALUE_W-1], value};
		if (row == ref_index_q) begin
			coef_next = (col == ref_index_q) ? COEF_NEG_ONE : val_ext;
		end else if (col == row) begin
			coef_next = val_ext - {ref_diag_q[VALUE_W-1], ref_diag_q};
		end else if (col == ref_index_q) begin
			coef_next = '0;
		end else begin
			coef_next = val_ext;
		end
	end

	// Only matrix entries and empty rows travel down the datapath.
	always_comb begin
		ctrl_next.vld   = accept && ((func == FUNC_ENTRY) || (func == FUNC_EMPTY));
		ctrl_next.empty = (func == FUNC_EMPTY);
		ctrl_next.last  = last_in_row;
		ctrl_next.row   = row;
	end

	// Stage 1: input register alongside the vector read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_next;
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= coef_next;
	end

	crmv_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s1   (ctrl_s1),
		.coef_s1   (coef_s1),
		.x_s1      (x_rd_s1),
		.done      (done),
		.out_row   (out_row),
		.y_value   (y_value),
		.saturated (saturated)
	);

endmodule

### hw/rtl/crmv_mac.sv
// ----------------------------------------------------------------------------
// crmv_mac: multiply, accumulate and result formatting
// Stage 2 forms the product of coefficient and vector element, stage 3 adds
// it into the saturating row accumulator, stage 4 negates, rescales and
// clips the row sum into the result register.
// ----------------------------------------------------------------------------
module crmv_mac import crmv_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  crmv_ctrl_t                ctrl_s1,
	input  logic signed [COEF_W-1:0]  coef_s1,
	input  logic signed [VALUE_W-1:0] x_s1,
	output logic                      done,
	output logic [IDX_W-1:0]          out_row,
	output logic [VALUE_W-1:0]        y_value,
	output logic                      saturated
);

	crmv_ctrl_t                ctrl_s2;
	crmv_ctrl_t                ctrl_s3;
	logic signed [ACC_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]   prod_full;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   sum_s3;
	logic signed [ACC_W:0]     sum_wide;
	logic signed [ACC_W-1:0]   sum_sat;
	logic signed [ACC_W-1:0]   neg_sum;
	logic                      in_range;
	logic [VALUE_W-1:0]        y_next;
	logic                      sat_next;
	logic                      done_q;
	logic [IDX_W-1:0]          out_row_q;
	logic [VALUE_W-1:0]        y_q;
	logic                      sat_q;

	// The coefficient stays above -2^32, so the product always fits 64 bits.
	assign prod_full = coef_s1 * x_s1;

	// Stage 2: product register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_full;
	end

	// Saturating add of the product into the running row sum.
	always_comb begin
		sum_wide = {acc_q[ACC_W-1], acc_q} + {prod_s2[ACC_W-1], prod_s2};
		if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
			sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sum_sat = sum_wide[ACC_W-1:0];
		end
	end

	// Stage 3: accumulator, cleared after the last entry of a row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			ctrl_s3 <= '0;
		end else begin
			if (ctrl_s2.vld && !ctrl_s2.empty) begin
				acc_q <= ctrl_s2.last ? '0 : sum_sat;
			end
			ctrl_s3.vld   <= ctrl_s2.vld && (ctrl_s2.empty || ctrl_s2.last);
			ctrl_s3.empty <= ctrl_s2.empty;
			ctrl_s3.last  <= ctrl_s2.last;
			ctrl_s3.row   <= ctrl_s2.row;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= sum_sat;
	end

	// Negate with saturation, drop the extra fraction bits and clip.
	always_comb begin
		neg_sum  = (sum_s3 == ACC_MIN) ? ACC_MAX : -sum_s3;
		in_range = (&neg_sum[ACC_W-1:FRAC_W+VALUE_W-1]) ||
			!(|neg_sum[ACC_W-1:FRAC_W+VALUE_W-1]);
		if (ctrl_s3.empty) begin
			y_next   = '0;
			sat_next = 1'b0;
		end else if (in_range) begin
			y_next   = neg_sum[FRAC_W+VALUE_W-1:FRAC_W];
			sat_next = 1'b0;
		end else begin
			y_next   = neg_sum[ACC_W-1] ? Y_MIN : Y_MAX;
			sat_next = 1'b1;
		end
	end

	// Stage 4: result register, shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_s3.vld;
		end
	end

	always_ff @(posedge clk) begin
		out_row_q <= ctrl_s3.row;
		y_q       <= y_next;
		sat_q     <= sat_next;
	end

	assign done      = done_q;
	assign out_row   = out_row_q;
	assign y_value   = y_q;
	assign saturated = sat_q;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: CSR matrix-vector product with reference-row shift
// Loads the dense vector, streams sparse row entries, empty rows and ignored
// codes through the command port, and mirrors every fixed-point row sum in a
// local predictor. Each strobed result is compared in order with the oldest
// predicted row sum, under several reference row and diagonal settings.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import crmv_pkg::*;

	// Code that the block must ignore.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int RESULT_LATENCY = 4;
	localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
	localparam int REPORT_LIMIT   = 40;
	localparam logic [VALUE_W-1:0] ONE_Q = 32'h0100_0000;

	typedef struct packed {
		logic [IDX_W-1:0]   row;
		logic [VALUE_W-1:0] y;
		logic               sat;
	} row_result_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic                 busy;
	logic [FUNC_W-1:0]    func        = FUNC_LOAD;
	logic [IDX_W-1:0]     row         = '0;
	logic [IDX_W-1:0]     col         = '0;
	logic [VALUE_W-1:0]   value       = '0;
	logic                 last_in_row = 1'b0;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = CFG_REF_INDEX;
	logic [VALUE_W-1:0]   cfg_data    = '0;
	logic                 done;
	logic [IDX_W-1:0]     out_row;
	logic [VALUE_W-1:0]   y_value;
	logic                 saturated;

	// Predictor state: vector mirror, accumulator and reference settings.
	logic signed [VALUE_W-1:0] x_mirror [X_DEPTH];
	bit                        x_written [X_DEPTH];
	logic [IDX_W-1:0]          written_cols [$];
	logic signed [ACC_W-1:0]   acc_model       = '0;
	logic [IDX_W-1:0]          ref_index_model = '0;
	logic signed [VALUE_W-1:0] ref_diag_model  = '0;
	row_result_t               expected_rows [$];

	int mismatch_count = 0;
	int items_sent     = 0;
	int burst_left     = 1;

	csr_matvec_ref_row_shift u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.row         (row),
		.col         (col),
		.value       (value),
		.last_in_row (last_in_row),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.out_row     (out_row),
		.y_value     (y_value),
		.saturated   (saturated)
	);

	// Clock with a 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// A fixed time limit ends a run that has hung.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Prints one line per mismatch, up to a limit, and counts all of them.
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("tb: mismatch at %0t ns: %s", $realtime, msg);
	endtask

	// Clips a wide value to the signed accumulator range.
	function automatic logic signed [ACC_W-1:0] clip_acc(input logic signed [127:0] v);
		if (v > ACC_MAX)
			return ACC_MAX;
		if (v < ACC_MIN)
			return ACC_MIN;
		return v[ACC_W-1:0];
	endfunction

	// Updates the mirror for one accepted item and queues the row sum it yields.
	task automatic predict_row_sum(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [VALUE_W-1:0] v, input logic last);
		logic signed [127:0] xw;
		logic signed [127:0] vw;
		logic signed [127:0] hw;
		logic signed [127:0] term;
		logic signed [127:0] negw;
		logic signed [127:0] yw;
		row_result_t         res;
		case (f)
			FUNC_LOAD: begin
				x_mirror[c] = v;
				if (!x_written[c]) begin
					x_written[c] = 1'b1;
					written_cols.push_back(c);
				end
			end
			FUNC_EMPTY: begin
				res.row = r;
				res.y   = '0;
				res.sat = 1'b0;
				expected_rows.push_back(res);
			end
			FUNC_ENTRY: begin
				xw = x_mirror[c];
				vw = $signed(v);
				hw = ref_diag_model;
				// The reference row negates x on its diagonal; other rows shift
				// their diagonal by h and drop the reference column.
				if (r == ref_index_model)
					term = (c == ref_index_model) ? -(xw <<< FRAC_W) : vw * xw;
				else if (c == r)
					term = (vw - hw) * xw;
				else if (c != ref_index_model)
					term = vw * xw;
				else
					term = '0;
				acc_model = clip_acc(acc_model + clip_acc(term));
				if (last) begin
					negw = (acc_model == ACC_MIN) ? ACC_MAX : -acc_model;
					yw = negw >>> FRAC_W;
					res.row = r;
					res.sat = 1'b1;
					if (yw > $signed(Y_MAX))
						res.y = Y_MAX;
					else if (yw < $signed(Y_MIN))
						res.y = Y_MIN;
					else begin
						res.y   = yw[VALUE_W-1:0];
						res.sat = 1'b0;
					end
					expected_rows.push_back(res);
					acc_model = '0;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Each strobed result is matched against the oldest predicted row sum.
	always @(posedge clk) begin : check_results
		row_result_t exp_r;
		if (arst_n && done) begin
			if (expected_rows.size() == 0) begin
				report_mismatch($sformatf("result for row %0d with none pending", out_row));
			end else begin
				exp_r = expected_rows.pop_front();
				if (out_row !== exp_r.row)
					report_mismatch($sformatf("out_row %0d, expected %0d", out_row, exp_r.row));
				if (y_value !== exp_r.y)
					report_mismatch($sformatf("row %0d: y_value %h, expected %h",
						exp_r.row, y_value, exp_r.y));
				if (saturated !== exp_r.sat)
					report_mismatch($sformatf("row %0d: saturated %b, expected %b",
						exp_r.row, saturated, exp_r.sat));
			end
		end
	end

	// Sends one item, predicts it on acceptance, and idles between bursts.
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [VALUE_W-1:0] v, input logic last);
		int gap;
		start       <= 1'b1;
		func        <= f;
		row         <= r;
		col         <= c;
		value       <= v;
		last_in_row <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_row_sum(f, r, c, v, last);
		if (f != FUNC_UNUSED)
			items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 20);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Holds off the sender until every predicted row sum has arrived.
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register; the valid stays high for a following write.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_REF_INDEX)
			ref_index_model = d[IDX_W-1:0];
		else
			ref_diag_model = d;
	endtask

	// Sets the reference row and diagonal once the block is idle.
	task automatic set_reference(input logic [IDX_W-1:0] ri, input logic [VALUE_W-1:0] h);
		wait_idle();
		cfg_write(CFG_REF_INDEX, {20'($urandom), ri});
		cfg_write(CFG_REF_DIAG, h);
		cfg_valid <= 1'b0;
	endtask

	// Mix of full-range, small, extreme and tiny fixed-point values.
	function automatic logic [VALUE_W-1:0] rand_value();
		int s;
		case ($urandom_range(0, 7))
			0, 1: s = int'($urandom);
			2, 3, 4, 5: s = int'($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
			6: begin
				case ($urandom_range(0, 4))
					0: s = int'(Y_MAX);
					1: s = int'(Y_MIN);
					2: s = 0;
					3: s = -1;
					default: s = 1;
				endcase
			end
			default: s = int'($urandom_range(0, 255)) - 128;
		endcase
		return VALUE_W'(s);
	endfunction

	function automatic logic [IDX_W-1:0] pick_written_col();
		return written_cols[$urandom_range(0, written_cols.size() - 1)];
	endfunction

	function automatic logic [IDX_W-1:0] pick_row();
		case ($urandom_range(0, 7))
			0: return ref_index_model;
			1: return IDX_W'($urandom);
			default: return pick_written_col();
		endcase
	endfunction

	// Sends one row of entries; only written vector entries are ever read.
	task automatic send_row(input bit terminate, input bit mixed);
		int               n;
		int               k;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] rf;
		logic [IDX_W-1:0] c;
		r = pick_row();
		n = $urandom_range(1, 6);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0, 1: c = x_written[r] ? r : pick_written_col();
				2: c = ref_index_model;
				default: c = pick_written_col();
			endcase
			rf = (mixed && $urandom_range(0, 2) == 0) ? pick_row() : r;
			send_item(FUNC_ENTRY, rf, c, rand_value(), terminate && (k == n - 1));
		end
	endtask

	task automatic load_random();
		logic [IDX_W-1:0] c;
		c = ($urandom_range(0, 3) == 0) ? pick_written_col() : IDX_W'($urandom);
		send_item(FUNC_LOAD, IDX_W'($urandom), c, rand_value(), 1'($urandom));
	endtask

	// Vector loads at the extremes, then a reference diagonal under reset settings.
	task automatic test_reset_config();
		send_item(FUNC_LOAD, 12'd0, 12'd0, Y_MAX, 1'b0);
		send_item(FUNC_LOAD, 12'd4095, 12'd4095, Y_MIN, 1'b1);
		send_item(FUNC_LOAD, 12'd0, 12'd5, ONE_Q, 1'b0);
		send_item(FUNC_LOAD, 12'd0, 12'd7, 32'hFF80_0000, 1'b0);
		send_item(FUNC_LOAD, 12'd0, 12'd12, 32'h0000_0001, 1'b0);
		send_item(FUNC_ENTRY, 12'd0, 12'd0, 32'h1234_5678, 1'b1);
	endtask

	// Reference row diagonal, shifted diagonal and skipped reference column.
	task automatic test_reference_shift();
		set_reference(12'd5, ONE_Q);
		send_item(FUNC_ENTRY, 12'd5, 12'd5, Y_MAX, 1'b0);
		send_item(FUNC_ENTRY, 12'd5, 12'd7, 32'h0200_0000, 1'b1);
		send_item(FUNC_ENTRY, 12'd7, 12'd5, 32'h1234_5678, 1'b0);
		send_item(FUNC_ENTRY, 12'd7, 12'd7, Y_MIN, 1'b0);
		send_item(FUNC_ENTRY, 12'd7, 12'd12, Y_MAX, 1'b1);
	endtask

	// Empty row and ignored code inside an open row, then a differing row field.
	task automatic test_row_boundaries();
		send_item(FUNC_ENTRY, 12'd9, 12'd12, 32'hFFFF_FFFF, 1'b0);
		send_item(FUNC_EMPTY, 12'd4095, 12'd0, 32'h0, 1'b0);
		send_item(FUNC_UNUSED, 12'd2748, 12'd12, 32'hFFFF_FFFF, 1'b1);
		send_item(FUNC_ENTRY, 12'd4095, 12'd4095, Y_MAX, 1'b1);
	endtask

	// Accumulator saturation at both bounds and rounding toward minus infinity.
	task automatic test_saturation_rounding();
		repeat (3) send_item(FUNC_ENTRY, 12'd0, 12'd0, Y_MAX, 1'b0);
		send_item(FUNC_ENTRY, 12'd0, 12'd12, 32'h0, 1'b1);
		send_item(FUNC_ENTRY, 12'd12, 12'd0, Y_MIN, 1'b0);
		send_item(FUNC_ENTRY, 12'd12, 12'd0, Y_MIN, 1'b0);
		send_item(FUNC_ENTRY, 12'd12, 12'd0, Y_MIN, 1'b1);
		send_item(FUNC_ENTRY, 12'd3, 12'd7, 32'hFFFF_FFFF, 1'b1);
		send_item(FUNC_ENTRY, 12'd3, 12'd7, 32'h0000_0001, 1'b1);
	endtask

	// Random phases, each under its own reference setting, mostly whole rows.
	task automatic test_random_phases();
		int                 phase;
		int                 target;
		logic [IDX_W-1:0]   ri;
		logic [VALUE_W-1:0] h;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin ri = 12'd0;    h = Y_MAX; end
				1: begin ri = 12'd4095; h = Y_MIN; end
				2: begin ri = pick_written_col(); h = '0; end
				default: begin ri = pick_written_col(); h = rand_value(); end
			endcase
			set_reference(ri, h);
			target = items_sent + 300;
			if (phase == 0)
				repeat (48) load_random();
			while (items_sent < target) begin
				case ($urandom_range(0, 19))
					14, 19: load_random();
					15: send_item(FUNC_EMPTY, IDX_W'($urandom), pick_written_col(),
						VALUE_W'($urandom), 1'($urandom));
					16: send_item(FUNC_UNUSED, IDX_W'($urandom), pick_written_col(),
						VALUE_W'($urandom), 1'($urandom));
					17: send_row(1'b0, 1'b0);
					18: send_row(1'b1, 1'b1);
					default: send_row(1'b1, 1'b0);
				endcase
			end
		end
	endtask

	// Reset once, run each test in turn, then give the verdict.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_reference_shift();
		test_row_boundaries();
		test_saturation_rounding();
		test_random_phases();
		wait_idle();
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
